// ===== design/brr_pkg.sv =====
// Shared types, widths and codes for the byte ring buffer.
// No dependencies; every other design file but brr_ram imports this package.
package brr_pkg;

   localparam int CNT_W       = 11;
   localparam int ACT_W       = 2;
   localparam int REQ_CNT_W   = 4;
   localparam int STAT_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int LANES       = 8;
   localparam int LANE_W      = 3;
   localparam int MAX_SIZE    = 1024;

   localparam int DEF_STORE_DEPTH = 1024;
   localparam int DEF_BURST_BYTES = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_SHORT   = 2'd2
   } status_type;

   typedef struct packed {
      logic [ACT_W-1:0]                 action;
      logic [REQ_CNT_W-1:0]             request_count;
      logic [LANES-1:0][BYTE_W-1:0]     in_bytes;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]                status;
      logic [CNT_W-1:0]                 count_value;
      logic [CNT_W-1:0]                 fill_level;
      logic [CNT_W-1:0]                 space_left;
      logic [LANES-1:0][BYTE_W-1:0]     out_bytes;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic step;
      logic commit;
      logic publish;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic steps_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/brr_channels.sv =====
// Handshake channel interfaces: command in, result out, size register write.
// Depends on brr_pkg for field widths.
interface brr_req_chan import brr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ACT_W-1:0]     action;
   logic [REQ_CNT_W-1:0] request_count;
   logic [BYTE_W-1:0]    in_byte_0;
   logic [BYTE_W-1:0]    in_byte_1;
   logic [BYTE_W-1:0]    in_byte_2;
   logic [BYTE_W-1:0]    in_byte_3;
   logic [BYTE_W-1:0]    in_byte_4;
   logic [BYTE_W-1:0]    in_byte_5;
   logic [BYTE_W-1:0]    in_byte_6;
   logic [BYTE_W-1:0]    in_byte_7;

   modport source (output valid, action, request_count, in_byte_0, in_byte_1, in_byte_2,
                   in_byte_3, in_byte_4, in_byte_5, in_byte_6, in_byte_7, input ready);
   modport sink   (input valid, action, request_count, in_byte_0, in_byte_1, in_byte_2,
                   in_byte_3, in_byte_4, in_byte_5, in_byte_6, in_byte_7, output ready);
endinterface

interface brr_rsp_chan import brr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [CNT_W-1:0]     count_value;
   logic [CNT_W-1:0]     fill_level;
   logic [CNT_W-1:0]     space_left;
   logic [BYTE_W-1:0]    out_byte_0;
   logic [BYTE_W-1:0]    out_byte_1;
   logic [BYTE_W-1:0]    out_byte_2;
   logic [BYTE_W-1:0]    out_byte_3;
   logic [BYTE_W-1:0]    out_byte_4;
   logic [BYTE_W-1:0]    out_byte_5;
   logic [BYTE_W-1:0]    out_byte_6;
   logic [BYTE_W-1:0]    out_byte_7;

   modport source (output valid, status, count_value, fill_level, space_left, out_byte_0,
                   out_byte_1, out_byte_2, out_byte_3, out_byte_4, out_byte_5, out_byte_6,
                   out_byte_7, input ready);
   modport sink   (input valid, status, count_value, fill_level, space_left, out_byte_0,
                   out_byte_1, out_byte_2, out_byte_3, out_byte_4, out_byte_5, out_byte_6,
                   out_byte_7, output ready);
endinterface

interface brr_csr_chan import brr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== design/brr_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module brr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

// ===== design/brr_ctrl.sv =====
// Command sequencer for the byte ring buffer.
// Depends on brr_pkg for the command and status structs.
module brr_ctrl import brr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type sts,
   output logic          idle,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_STEP,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      idle     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (sts.steps_done) begin
               state_in = S_DRAIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DRAIN: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/brr_datapath.sv =====
// Pointers, size register, byte lanes and result register of the ring buffer.
// Depends on brr_pkg and brr_ram.
module brr_datapath import brr_pkg::*; #(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int BURST_BYTES = DEF_BURST_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic          csr_we,
   input  logic [CNT_W-1:0] csr_data,
   input  req_item_type  req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_item
);

   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int PTR_W      = (ADDR_W < CNT_W) ? ADDR_W : CNT_W;
   localparam int SIZE_RESET = (STORE_DEPTH > MAX_SIZE) ? MAX_SIZE : STORE_DEPTH;

   function automatic logic [CNT_W-1:0] held(input logic [CNT_W-1:0] sz,
                                             input logic [CNT_W-1:0] rd,
                                             input logic [CNT_W-1:0] wr,
                                             input logic ph);
      logic [CNT_W-1:0] res;
      if (rd <= wr && !ph) begin
         res = wr - rd;
      end else if (rd == wr && ph) begin
         res = sz;
      end else begin
         res = sz - rd + wr;
      end
      return res;
   endfunction

   // architectural state
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic                 phase_ff, phase_in;
   // command in flight
   action_type           action_ff, action_in;
   logic [REQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LANES-1:0][BYTE_W-1:0] in_bytes_ff, in_bytes_in;
   logic [LANES-1:0][BYTE_W-1:0] out_bytes_ff, out_bytes_in;
   logic [REQ_CNT_W-1:0] steps_ff, steps_in;
   logic [REQ_CNT_W-1:0] step_ff, step_in;
   logic [PTR_W-1:0]     cursor_ff, cursor_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 ok_ff, ok_in;
   status_type           status_ff, status_in;
   logic [CNT_W-1:0]     cval_ff, cval_in;
   logic                 cap_ff, cap_in;
   logic [LANE_W-1:0]    cap_lane_ff, cap_lane_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;

   logic [CNT_W-1:0]     sz;
   logic [CNT_W-1:0]     fill_now;
   logic [CNT_W-1:0]     space_now;
   logic [CNT_W-1:0]     next_wide;
   logic                 wrap_now;
   logic [REQ_CNT_W-1:0] req_cnt;
   logic [LANE_W-1:0]    lane;
   logic                 ram_en;
   logic                 ram_we;
   logic [BYTE_W-1:0]    ram_rdata;

   always_comb begin
      if (size_ff == '0) begin
         sz = CNT_W'(1);
      end else if (32'(size_ff) > STORE_DEPTH) begin
         sz = CNT_W'(STORE_DEPTH);
      end else begin
         sz = size_ff;
      end
   end

   assign fill_now  = held(sz, CNT_W'(rd_ptr_ff), CNT_W'(wr_ptr_ff), phase_ff);
   assign space_now = sz - fill_now;
   assign next_wide = CNT_W'(cursor_ff) + CNT_W'(1);
   assign wrap_now  = (next_wide >= sz);
   assign lane      = step_ff[LANE_W-1:0];
   assign req_cnt   = (32'(req_item.request_count) > BURST_BYTES) ?
                      REQ_CNT_W'(BURST_BYTES) : req_item.request_count;

   assign ram_en = cmd.step;
   assign ram_we = cmd.step && (action_ff == ACT_PUSH);

   brr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ADDR_W'(cursor_ff)),
      .wdata (in_bytes_ff[lane]),
      .rdata (ram_rdata)
   );

   always_comb begin
      size_in      = size_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      phase_in     = phase_ff;
      action_in    = action_ff;
      cnt_in       = cnt_ff;
      in_bytes_in  = in_bytes_ff;
      out_bytes_in = out_bytes_ff;
      steps_in     = steps_ff;
      step_in      = step_ff;
      cursor_in    = cursor_ff;
      wrapped_in   = wrapped_ff;
      ok_in        = ok_ff;
      status_in    = status_ff;
      cval_in      = cval_ff;
      cap_in       = 1'b0;
      cap_lane_in  = cap_lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         size_in   = csr_data;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         phase_in  = 1'b0;
      end

      if (cmd.load) begin
         action_in    = action_type'(req_item.action);
         cnt_in       = req_cnt;
         in_bytes_in  = req_item.in_bytes;
         out_bytes_in = '0;
      end

      if (cmd.eval) begin
         step_in    = '0;
         wrapped_in = 1'b0;
         cursor_in  = (action_ff == ACT_PUSH) ? wr_ptr_ff : rd_ptr_ff;
         case (action_ff)
            ACT_PUSH: begin
               ok_in     = (space_now >= CNT_W'(cnt_ff));
               status_in = ok_in ? ST_DONE : ST_REFUSED;
               cval_in   = ok_in ? CNT_W'(cnt_ff) : space_now;
            end
            ACT_POP: begin
               ok_in     = (fill_now >= CNT_W'(cnt_ff));
               status_in = ok_in ? ST_DONE : ST_REFUSED;
               cval_in   = ok_in ? CNT_W'(cnt_ff) : fill_now;
            end
            ACT_PEEK: begin
               ok_in     = (fill_now >= CNT_W'(cnt_ff));
               status_in = ok_in ? ST_DONE : ST_SHORT;
               cval_in   = ok_in ? CNT_W'(cnt_ff) : '0;
            end
            default: begin
               ok_in     = 1'b1;
               status_in = ST_DONE;
               cval_in   = '0;
            end
         endcase
         steps_in = (ok_in && action_ff != ACT_FLUSH) ? cnt_ff : '0;
      end

      if (cmd.step) begin
         step_in     = step_ff + REQ_CNT_W'(1);
         cursor_in   = wrap_now ? '0 : PTR_W'(next_wide);
         wrapped_in  = wrapped_ff | wrap_now;
         cap_in      = (action_ff != ACT_PUSH);
         cap_lane_in = lane;
      end

      if (cap_ff) begin
         out_bytes_in[cap_lane_ff] = ram_rdata;
      end

      if (cmd.commit) begin
         case (action_ff)
            ACT_PUSH: begin
               if (ok_ff) begin
                  wr_ptr_in = cursor_ff;
                  if (wrapped_ff) begin
                     phase_in = 1'b1;
                  end
               end
            end
            ACT_POP: begin
               if (ok_ff) begin
                  rd_ptr_in = cursor_ff;
                  if (wrapped_ff) begin
                     phase_in = 1'b0;
                  end
               end
            end
            ACT_FLUSH: begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               phase_in  = 1'b0;
            end
            default: ;
         endcase
      end

      if (cmd.publish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status_ff;
         rsp_in.count_value = cval_ff;
         rsp_in.fill_level  = fill_now;
         rsp_in.space_left  = space_now;
         rsp_in.out_bytes   = out_bytes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CNT_W'(SIZE_RESET);
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         phase_ff     <= 1'b0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         phase_ff     <= phase_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      cnt_ff       <= cnt_in;
      in_bytes_ff  <= in_bytes_in;
      out_bytes_ff <= out_bytes_in;
      steps_ff     <= steps_in;
      step_ff      <= step_in;
      cursor_ff    <= cursor_in;
      wrapped_ff   <= wrapped_in;
      ok_ff        <= ok_in;
      status_ff    <= status_in;
      cval_ff      <= cval_in;
      cap_lane_ff  <= cap_lane_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.steps_done = (step_ff == steps_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item       = rsp_ff;

endmodule

// ===== design/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: channels, sequencer and datapath.
// Depends on brr_pkg, brr_channels, brr_ctrl, brr_datapath (and brr_ram below it).
//
// Usage:
//   req_chan carries one command item: push, pop, peek or flush with up to
//   BURST_BYTES bytes. rsp_chan returns exactly one result item per command
//   with status, count, fill level, free space and the bytes read.
//   csr_chan writes the size register (entries in use); a write also empties
//   the buffer. Write it only while no command is in flight.
//   One command is worked on at a time. The byte store has a single port, so
//   a command that moves n bytes accesses it one byte after another, and the
//   next command can be accepted in the cycle after its result is loaded.
//   The result sits in an output register until taken; if rsp_chan stalls,
//   the next command is still accepted and worked on, and its result waits
//   in the last step until the output register is free.
//   Reset (synchronous) empties the buffer and sets the size to the store
//   depth, at most 1024. The store contents are not cleared.
module byte_ring_buffer import brr_pkg::*; #(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int BURST_BYTES = DEF_BURST_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   brr_req_chan.sink   req_chan,
   brr_rsp_chan.source rsp_chan,
   brr_csr_chan.sink   csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic          idle;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   logic          rsp_valid;

   assign req_chan.ready = idle;
   assign csr_chan.ready = idle;

   assign req_item.action        = req_chan.action;
   assign req_item.request_count = req_chan.request_count;
   assign req_item.in_bytes[0]   = req_chan.in_byte_0;
   assign req_item.in_bytes[1]   = req_chan.in_byte_1;
   assign req_item.in_bytes[2]   = req_chan.in_byte_2;
   assign req_item.in_bytes[3]   = req_chan.in_byte_3;
   assign req_item.in_bytes[4]   = req_chan.in_byte_4;
   assign req_item.in_bytes[5]   = req_chan.in_byte_5;
   assign req_item.in_bytes[6]   = req_chan.in_byte_6;
   assign req_item.in_bytes[7]   = req_chan.in_byte_7;

   brr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .sts       (sts),
      .idle      (idle),
      .cmd       (cmd)
   );

   brr_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .BURST_BYTES (BURST_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_chan.valid && idle),
      .csr_data  (csr_chan.data),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.status      = rsp_item.status;
   assign rsp_chan.count_value = rsp_item.count_value;
   assign rsp_chan.fill_level  = rsp_item.fill_level;
   assign rsp_chan.space_left  = rsp_item.space_left;
   assign rsp_chan.out_byte_0  = rsp_item.out_bytes[0];
   assign rsp_chan.out_byte_1  = rsp_item.out_bytes[1];
   assign rsp_chan.out_byte_2  = rsp_item.out_bytes[2];
   assign rsp_chan.out_byte_3  = rsp_item.out_bytes[3];
   assign rsp_chan.out_byte_4  = rsp_item.out_bytes[4];
   assign rsp_chan.out_byte_5  = rsp_item.out_bytes[5];
   assign rsp_chan.out_byte_6  = rsp_item.out_bytes[6];
   assign rsp_chan.out_byte_7  = rsp_item.out_bytes[7];

endmodule
